>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ZCI_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define ZCI_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle implication failed");

`endif

>>> rtl/core/zci_pkg.sv
package zci_pkg;

  localparam int KEY_W  = 32;
  localparam int IDX_W  = 16;
  localparam int FRAC_W = 32;
  localparam int MAG_W  = KEY_W + 1;
  localparam int CNT_W  = $clog2(FRAC_W);

  // Sample index stops at min(MAX_SAMPLES - 1, 2^IDX_W - 1)
  localparam longint MAX_SAMPLES = 64'd65536;
  localparam longint IDX_MAX     = (64'd1 << IDX_W) - 64'd1;
  localparam logic [IDX_W-1:0] IDX_LIMIT =
    (MAX_SAMPLES - 64'd1 > IDX_MAX) ? IDX_W'(IDX_MAX) : IDX_W'(MAX_SAMPLES - 64'd1);

  typedef struct packed {
    logic              done;
    logic [FRAC_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] step_x;
    logic [MAG_W-1:0] step_y;
  } mul_res_t;

endpackage

>>> rtl/core/zci_div.sv
// Restoring radix-2 fraction divider: quot = floor(num * 2^FRAC_W / den),
// one quotient bit per cycle, MSB first. Requires num < den.
module zci_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [zci_pkg::FRAC_W-1:0] num,
  input  logic [zci_pkg::MAG_W-1:0]  den,
  output zci_pkg::div_res_t          res
);
  import zci_pkg::*;

  logic [MAG_W:0]    rem_r, rem_nxt;
  logic [FRAC_W-1:0] quot_r, quot_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [MAG_W:0]    rem_sh;
  logic [MAG_W+1:0]  diff;
  logic              fits;

  // Trial subtract of the doubled remainder
  assign rem_sh = {rem_r[MAG_W-1:0], 1'b0};
  assign diff   = {1'b0, rem_sh} - {2'b00, den};
  assign fits   = !diff[MAG_W+1];

  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {2'b00, num};
      quot_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[MAG_W:0] : rem_sh;
      quot_nxt = {quot_r[FRAC_W-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(FRAC_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Advance control under reset, data free-running
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

>>> rtl/core/zci_mul.sv
// Two-lane shift-add multiplier: step = round(mag * frac / 2^FRAC_W),
// one multiplier bit per cycle, LSB first, then a rounding step.
module zci_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [zci_pkg::FRAC_W-1:0] frac,
  input  logic [zci_pkg::MAG_W-1:0]  mag_x,
  input  logic [zci_pkg::MAG_W-1:0]  mag_y,
  output zci_pkg::mul_res_t          res
);
  import zci_pkg::*;

  logic [MAG_W-1:0]  accx_r, accx_nxt, accy_r, accy_nxt;
  logic [FRAC_W-1:0] lowx_r, lowx_nxt, lowy_r, lowy_nxt;
  logic [FRAC_W-1:0] fsr_r, fsr_nxt;
  logic [MAG_W-1:0]  stepx_r, stepx_nxt, stepy_r, stepy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              rnd_r, rnd_nxt;
  logic              done_r, done_nxt;
  logic [MAG_W:0]    sumx, sumy;

  // Add the multiplicand when the current multiplier bit is set
  assign sumx = {1'b0, accx_r} + (fsr_r[0] ? {1'b0, mag_x} : '0);
  assign sumy = {1'b0, accy_r} + (fsr_r[0] ? {1'b0, mag_y} : '0);

  always_comb begin
    accx_nxt  = accx_r;
    accy_nxt  = accy_r;
    lowx_nxt  = lowx_r;
    lowy_nxt  = lowy_r;
    fsr_nxt   = fsr_r;
    stepx_nxt = stepx_r;
    stepy_nxt = stepy_r;
    cnt_nxt   = cnt_r;
    busy_nxt  = busy_r;
    rnd_nxt   = 1'b0;
    done_nxt  = 1'b0;
    if (start) begin
      accx_nxt = '0;
      accy_nxt = '0;
      fsr_nxt  = frac;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Shift the partial product right by one bit
      accx_nxt = sumx[MAG_W:1];
      accy_nxt = sumy[MAG_W:1];
      lowx_nxt = {sumx[0], lowx_r[FRAC_W-1:1]};
      lowy_nxt = {sumy[0], lowy_r[FRAC_W-1:1]};
      fsr_nxt  = {1'b0, fsr_r[FRAC_W-1:1]};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(FRAC_W - 1)) begin
        busy_nxt = 1'b0;
        rnd_nxt  = 1'b1;
      end
    end else if (rnd_r) begin
      // Round half up on the top dropped bit
      stepx_nxt = accx_r + MAG_W'(lowx_r[FRAC_W-1]);
      stepy_nxt = accy_r + MAG_W'(lowy_r[FRAC_W-1]);
      done_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      rnd_r  <= rnd_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    accx_r  <= accx_nxt;
    accy_r  <= accy_nxt;
    lowx_r  <= lowx_nxt;
    lowy_r  <= lowy_nxt;
    fsr_r   <= fsr_nxt;
    stepx_r <= stepx_nxt;
    stepy_r <= stepy_nxt;
  end

  assign res.done   = done_r;
  assign res.step_x = stepx_r;
  assign res.step_y = stepy_r;

endmodule

>>> rtl/core/zero_crossing_interpolator_top.sv
// Zero-crossing interpolator.
// Input channel (in_valid/in_ready): one sample word per transfer, a signed
// Q15.16 key and value plus series_start, which begins a new series.
// Output channel (out_valid/out_ready): one word per crossing, holding the
// interpolated key, the residual value of the line at that key and the
// index of the left sample within its series.
// A sample that forms no crossing is absorbed in the cycle it is accepted;
// in_ready stays high, so such samples stream at one per cycle.
// A sample that forms a crossing goes through a setup state, 32 divider
// steps, the start of the two-lane shift-add multiplier, 32 multiplier steps,
// a rounding step, the move to the output state and the load of the output
// register before its output word is presented.
// in_ready stays low until that load, so the next sample after a crossing is
// accepted only once the state has returned to idle after the load.
// Reset (rst_n low, synchronous) drops the held sample, zeroes the index and
// empties the output register.
// When the receiver stalls, the output word holds; new samples are still
// taken while it waits, and a further crossing waits after its arithmetic
// until the output register frees.
module zero_crossing_interpolator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [zci_pkg::KEY_W-1:0] in_sample_key,
  input  logic signed [zci_pkg::KEY_W-1:0] in_sample_value,
  input  logic                             in_series_start,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [zci_pkg::KEY_W-1:0] out_crossing_key,
  output logic signed [zci_pkg::KEY_W-1:0] out_crossing_residual,
  output logic        [zci_pkg::IDX_W-1:0] out_left_index
);
  import zci_pkg::*;

  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [KEY_W-1:0] prev_key_r, prev_val_r, prev_mag_r;
  logic             have_prev_r;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0] x1_r, y1_r, a_r;
  logic [IDX_W-1:0] idx_r;
  logic             dxneg_r, dyneg_r;
  logic [MAG_W-1:0] magx_r, den_r;
  logic             out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0] out_key_r, out_res_r;
  logic [IDX_W-1:0] out_idx_r;

  logic             accept, crossing, load;
  logic [KEY_W-1:0] in_mag;
  logic [MAG_W-1:0] dx_fwd, dx_back;
  logic             div_start, mul_start;
  div_res_t         div_res;
  mul_res_t         mul_res;
  logic [MAG_W:0]   key_sum, res_sum;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Strictly opposite signs with the held sample; zero never counts
  assign crossing = !in_series_start && have_prev_r &&
                    ((prev_val_r[KEY_W-1] && !in_sample_value[KEY_W-1] &&
                      (in_sample_value != '0)) ||
                     (!prev_val_r[KEY_W-1] && (prev_val_r != '0) &&
                      in_sample_value[KEY_W-1]));

  assign in_mag = in_sample_value[KEY_W-1] ? (~in_sample_value + 1'b1) : in_sample_value;

  // Saturating sample index
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_series_start || !have_prev_r) begin
        cnt_nxt = '0;
      end else if (cnt_r < IDX_LIMIT) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  // Key difference both ways; pick the nonnegative one in setup
  assign dx_fwd  = {prev_key_r[KEY_W-1], prev_key_r} - {x1_r[KEY_W-1], x1_r};
  assign dx_back = {x1_r[KEY_W-1], x1_r} - {prev_key_r[KEY_W-1], prev_key_r};

  assign div_start = (state_r == S_SETUP);
  assign mul_start = (state_r == S_DIV) && div_res.done;
  assign load      = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Final interpolation adds: base +/- rounded step
  assign key_sum = dxneg_r ? ({{2{x1_r[KEY_W-1]}}, x1_r} - {1'b0, mul_res.step_x})
                           : ({{2{x1_r[KEY_W-1]}}, x1_r} + {1'b0, mul_res.step_x});
  assign res_sum = dyneg_r ? ({{2{y1_r[KEY_W-1]}}, y1_r} - {1'b0, mul_res.step_y})
                           : ({{2{y1_r[KEY_W-1]}}, y1_r} + {1'b0, mul_res.step_y});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept && crossing) state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_DIV;
      S_DIV:   if (div_res.done) state_nxt = S_MUL;
      S_MUL:   if (mul_res.done) state_nxt = S_OUT;
      S_OUT:   if (load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      prev_key_r  <= '0;
      prev_val_r  <= '0;
      prev_mag_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        have_prev_r <= 1'b1;
        prev_key_r  <= in_sample_key;
        prev_val_r  <= in_sample_value;
        prev_mag_r  <= in_mag;
      end
    end
  end

  // Capture the left sample and operands of a crossing, and load the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      x1_r    <= prev_key_r;
      y1_r    <= prev_val_r;
      a_r     <= prev_mag_r;
      idx_r   <= cnt_r;
      dyneg_r <= in_sample_value[KEY_W-1];
    end
    if (state_r == S_SETUP) begin
      den_r   <= {1'b0, a_r} + {1'b0, prev_mag_r};
      dxneg_r <= dx_fwd[MAG_W-1];
      magx_r  <= dx_fwd[MAG_W-1] ? dx_back : dx_fwd;
    end
    if (load) begin
      out_key_r <= key_sum[KEY_W-1:0];
      out_res_r <= res_sum[KEY_W-1:0];
      out_idx_r <= idx_r;
    end
  end

  zci_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (a_r),
    .den   ({1'b0, a_r} + {1'b0, prev_mag_r}),
    .res   (div_res)
  );

  zci_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .frac  (div_res.quot),
    .mag_x (magx_r),
    .mag_y (den_r),
    .res   (mul_res)
  );

  assign out_valid             = out_valid_r;
  assign out_crossing_key      = out_key_r;
  assign out_crossing_residual = out_res_r;
  assign out_left_index        = out_idx_r;

  `ZCI_ASSERT_IMP(a_div_done_in_div, div_res.done, state_r == S_DIV)
  `ZCI_ASSERT_IMP(a_mul_done_in_mul, mul_res.done, state_r == S_MUL)
  `ZCI_ASSERT_NXT(a_cross_to_setup, accept && crossing, state_r == S_SETUP)
  `ZCI_ASSERT_NXT(a_plain_stays_idle, accept && !crossing, state_r == S_IDLE)

endmodule
